[rtl/qlshd_pkg.sv]
// Shared constants and types for the quad line sensor hysteresis/debounce block.
// No dependencies; imported by the top level and its port checker.
package qlshd_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int MARGIN_BITS = 8;
  localparam int FRAMES_BITS = 8;

  // Stream word widths: four samples in, three 4-bit fields out (padded to 16).
  localparam int IN_W    = CHANNELS * SAMPLE_BITS;
  localparam int OUT_W   = 16;
  localparam int FIELD_W = CHANNELS;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MARGIN_BITS-1:0] margin_t;
  typedef logic [FRAMES_BITS-1:0] frames_t;
  typedef logic [FIELD_W-1:0]     chan_bits_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_BL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_BR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd6;

  // Register reset values
  localparam sample_t    THR_RESET    = 10'd512;
  localparam margin_t    MARGIN_RESET = 8'd20;
  localparam frames_t    FRAMES_RESET = 8'd3;
  localparam chan_bits_t INVERT_RESET = 4'd0;

  localparam sample_t SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

endpackage

[rtl/quad_line_sensor_hysteresis_debounce.sv]
// Top level: four-channel line sensor threshold, hysteresis and debounce.
// Depends on qlshd_pkg; the port checker in qlshd_checker.sv binds to it.
//
//  channel  | direction | word fields (lowest bit up)                | width
//  ---------+-----------+--------------------------------------------+------
//  in_      | slave     | sample_fl, sample_fr, sample_bl, sample_br | 40
//  out_     | master    | raw_line_bits, hysteresis_bits, stable_bits| 16
//  cfg_     | write     | index 0..6, data up to 10 bits             | 3/10
//
// Cycles: one word accepted per clock unless stalled; with the output slot
// free its result is in the output register on the next edge, else it waits
// in the skid entry. All per-channel compares and the debounce counter update
// sit in one combinational pass between the accepted word and that register.
// Stalls: a two-deep output buffer (output register plus skid) keeps in_tready
// a registered signal; it drops only while both entries hold results.
// Reset: rst_n, synchronous, active low; clears state, buffer valids and
// loads register reset values.
module quad_line_sensor_hysteresis_debounce #(
  parameter int COUNT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: sample_front_left[9:0], sample_front_right[19:10],
  //           sample_back_left[29:20], sample_back_right[39:30]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qlshd_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: raw_line_bits[3:0], hysteresis_bits[7:4], stable_bits[11:8],
  //            zero[15:12]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [qlshd_pkg::OUT_W-1:0]      out_tdata,
  input  logic                             cfg_we,
  input  logic [qlshd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qlshd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qlshd_pkg::*;

  // Counter is compared against the 8-bit frame setting at the wider of both.
  localparam int CMP_W = (COUNT_BITS > FRAMES_BITS) ? COUNT_BITS : FRAMES_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  sample_t    thr_r [CHANNELS];
  margin_t    margin_r;
  frames_t    frames_r;
  chan_bits_t invert_r;

  // Per-channel state
  chan_bits_t              hold_r,    hold_nxt;
  chan_bits_t              stable_r,  stable_nxt;
  chan_bits_t              pending_r, pending_nxt;
  logic [COUNT_BITS-1:0]   cnt_r   [CHANNELS];
  logic [COUNT_BITS-1:0]   cnt_nxt [CHANNELS];

  // Combinational per-channel terms
  sample_t                 smp     [CHANNELS];
  logic [SAMPLE_BITS:0]    hi_sum  [CHANNELS];
  sample_t                 hi_bnd  [CHANNELS];
  sample_t                 lo_bnd  [CHANNELS];
  logic [COUNT_BITS-1:0]   cnt_inc [CHANNELS];
  chan_bits_t              raw_c;
  chan_bits_t              hyst_c;

  // Output buffer
  logic                    out_valid_r, skid_valid_r;
  logic [OUT_W-1:0]        out_data_r,  skid_data_r;
  logic [OUT_W-1:0]        res_word;

  logic                    in_acc;
  logic                    out_free;

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) thr_r[i] <= THR_RESET;
      margin_r <= MARGIN_RESET;
      frames_r <= FRAMES_RESET;
      invert_r <= INVERT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THR_FL: thr_r[0] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THR_FR: thr_r[1] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THR_BL: thr_r[2] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_THR_BR: thr_r[3] <= cfg_data[SAMPLE_BITS-1:0];
        CFG_MARGIN: margin_r <= cfg_data[MARGIN_BITS-1:0];
        CFG_FRAMES: frames_r <= cfg_data[FRAMES_BITS-1:0];
        CFG_INVERT: invert_r <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // One pass over the frame: channels are independent of each other.
  always_comb begin
    hold_nxt    = hold_r;
    stable_nxt  = stable_r;
    pending_nxt = pending_r;
    raw_c       = '0;
    hyst_c      = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      smp[i]    = in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      cnt_nxt[i] = cnt_r[i];

      // Bounds saturate at the converter range.
      hi_sum[i] = {1'b0, thr_r[i]} + {{(SAMPLE_BITS+1-MARGIN_BITS){1'b0}}, margin_r};
      hi_bnd[i] = hi_sum[i][SAMPLE_BITS] ? SAMPLE_MAX : hi_sum[i][SAMPLE_BITS-1:0];
      lo_bnd[i] = (thr_r[i] > {{(SAMPLE_BITS-MARGIN_BITS){1'b0}}, margin_r})
                ? thr_r[i] - {{(SAMPLE_BITS-MARGIN_BITS){1'b0}}, margin_r}
                : '0;

      // Hold is kept before inversion.
      if (smp[i] >= hi_bnd[i])      hold_nxt[i] = 1'b1;
      else if (smp[i] < lo_bnd[i])  hold_nxt[i] = 1'b0;

      raw_c[i]  = (smp[i] >= thr_r[i]) ^ invert_r[i];
      hyst_c[i] = hold_nxt[i] ^ invert_r[i];

      // Saturating count of frames that agree with the pending level.
      cnt_inc[i] = (cnt_r[i] == CNT_MAX) ? cnt_r[i] : cnt_r[i] + 1'b1;

      if (hyst_c[i] == stable_r[i]) begin
        pending_nxt[i] = stable_r[i];
        cnt_nxt[i]     = '0;
      end else if (hyst_c[i] == pending_r[i]) begin
        if (CMP_W'(cnt_inc[i]) >= CMP_W'(frames_r)) begin
          stable_nxt[i] = hyst_c[i];
          cnt_nxt[i]    = '0;
        end else begin
          cnt_nxt[i] = cnt_inc[i];
        end
      end else begin
        pending_nxt[i] = hyst_c[i];
        cnt_nxt[i]     = {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
    res_word = {{(OUT_W-3*FIELD_W){1'b0}}, stable_nxt, hyst_c, raw_c};
  end

  // Advance channel state only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r    <= '0;
      stable_r  <= '0;
      pending_r <= '0;
      for (int i = 0; i < CHANNELS; i++) cnt_r[i] <= '0;
    end else if (in_acc) begin
      hold_r    <= hold_nxt;
      stable_r  <= stable_nxt;
      pending_r <= pending_nxt;
      for (int i = 0; i < CHANNELS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  // Output register with skid: fill the output slot from skid first, then
  // from the new result; park the result in skid while the output stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_word;
    end else if (in_acc) begin
      skid_data_r <= res_word;
    end
  end

endmodule

[rtl/qlshd_checker.sv]
// Port-level checker for quad_line_sensor_hysteresis_debounce, with its bind.
// Depends on qlshd_pkg; sees only the top level's ports.
module qlshd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [qlshd_pkg::OUT_W-1:0] out_tdata
);
  import qlshd_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  // Pad bits above the three result fields stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:3*FIELD_W] == '0)
    else $error("result pad bits not zero");

  // Input back-pressure only while a result is waiting.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // An accepted word with a free output shows its result on the next edge.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (!out_tvalid || out_tready) |=> out_tvalid)
    else $error("result missing one cycle after accept");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind quad_line_sensor_hysteresis_debounce qlshd_checker u_qlshd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
